// ----- rtl/core/bbsf_pkg.sv -----
// Package for the bounded byte stream FIFO: widths, reset constants,
// command codes and the status bundle shared by the core and the top level.
// No dependencies.
package bbsf_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int BYTE_W        = 8;
  localparam int CAP_W         = 11;
  localparam int TOTAL_W       = 64;
  localparam int MODE_W        = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  front_byte;
    logic               front_valid;
    logic [CAP_W-1:0]   occupancy;
    logic [CAP_W-1:0]   free_room;
    logic [TOTAL_W-1:0] total_pushed;
    logic [TOTAL_W-1:0] total_popped;
    logic               closed;
    logic               finished;
    logic               error;
  } status_t;

endpackage

// ----- rtl/core/bounded_byte_stream_fifo.sv -----
// Top level of the bounded byte stream FIFO: command handshake, capacity
// register, result strobe; instantiates bbsf_core and bbsf_ram.
// Depends on bbsf_pkg.
//
//   channel   ports                              handshake
//   command   start, busy, in_mode/push_byte/... taken when start & !busy
//   result    out_valid, out_front_byte ...      one cycle, no back-pressure
//   config    cfg_valid, cfg_ready, cfg_data     written when valid & ready
//
// One command per cycle while busy is low; its result shows in the cycle after acceptance.
// The front byte comes from the registered store read at the new read pointer,
// with a push into an empty FIFO forwarded around the store.
// busy is high for the first cycle after reset, low from then on.
// Reset clears pointers, count, totals and flags; capacity returns to 1024.
module bounded_byte_stream_fifo #(
  parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bbsf_pkg::MODE_W-1:0]  in_mode,
  input  logic [bbsf_pkg::BYTE_W-1:0]  in_push_byte,
  input  logic [bbsf_pkg::CAP_W-1:0]   in_pop_count,
  output logic                         out_valid,
  output logic [bbsf_pkg::BYTE_W-1:0]  out_front_byte,
  output logic                         out_front_valid,
  output logic [bbsf_pkg::CAP_W-1:0]   out_occupancy,
  output logic [bbsf_pkg::CAP_W-1:0]   out_free_room,
  output logic [bbsf_pkg::TOTAL_W-1:0] out_total_pushed,
  output logic [bbsf_pkg::TOTAL_W-1:0] out_total_popped,
  output logic                         out_closed,
  output logic                         out_finished,
  output logic                         out_error,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bbsf_pkg::CAP_W-1:0]   cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                        busy_r, out_valid_r, take;
  logic [bbsf_pkg::CAP_W-1:0]  cap_r;
  logic                        ram_we;
  logic [PTR_W-1:0]            ram_waddr, ram_raddr;
  logic [bbsf_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
  bbsf_pkg::status_t           status;

  assign take      = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      cap_r       <= bbsf_pkg::CAP_RESET;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= take;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  bbsf_core #(.DEPTH(DEPTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .mode      (in_mode),
    .push_byte (in_push_byte),
    .pop_count (in_pop_count),
    .capacity  (cap_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .status    (status)
  );

  bbsf_ram #(.WIDTH(bbsf_pkg::BYTE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_front_byte   = status.front_byte;
  assign out_front_valid  = status.front_valid;
  assign out_occupancy    = status.occupancy;
  assign out_free_room    = status.free_room;
  assign out_total_pushed = status.total_pushed;
  assign out_total_popped = status.total_popped;
  assign out_closed       = status.closed;
  assign out_finished     = status.finished;
  assign out_error        = status.error;

endmodule

// ----- rtl/core/bbsf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bbsf_core.sv -----
// FIFO state and per-command update: pointers, count, totals and flags,
// with the front-byte read issued to the byte store at the new read pointer.
// Depends on bbsf_pkg.
module bbsf_core #(
  parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [bbsf_pkg::MODE_W-1:0]  mode,
  input  logic [bbsf_pkg::BYTE_W-1:0]  push_byte,
  input  logic [bbsf_pkg::CAP_W-1:0]   pop_count,
  input  logic [bbsf_pkg::CAP_W-1:0]   capacity,
  output logic                         ram_we,
  output logic [$clog2(DEPTH)-1:0]     ram_waddr,
  output logic [bbsf_pkg::BYTE_W-1:0]  ram_wdata,
  output logic [$clog2(DEPTH)-1:0]     ram_raddr,
  input  logic [bbsf_pkg::BYTE_W-1:0]  ram_rdata,
  output bbsf_pkg::status_t            status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > bbsf_pkg::CAP_W) ? CNT_W : bbsf_pkg::CAP_W;
  localparam int TW    = bbsf_pkg::TOTAL_W;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0]  rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]     pushed_r, pushed_nxt, popped_r, popped_nxt;
  logic              closed_r, closed_nxt, err_r, err_nxt;
  logic              bypass_r, bypass_nxt;
  logic [bbsf_pkg::BYTE_W-1:0] byte_r;
  logic [CMP_W-1:0]  room_r, room_nxt;

  bbsf_pkg::mode_t   cmd;
  logic [CMP_W-1:0]  cap_eff, cnt_ext, pop_ext, n_ext, cnt_nxt_ext;
  logic [CNT_W-1:0]  n;
  logic              push_ok;

  always_comb begin
    cmd     = bbsf_pkg::mode_t'(mode);
    cap_eff = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
    cnt_ext = CMP_W'(cnt_r);
    pop_ext = CMP_W'(pop_count);
    n_ext   = (pop_ext > cnt_ext) ? cnt_ext : pop_ext;
    n       = n_ext[CNT_W-1:0];
    push_ok = take && (cmd == bbsf_pkg::MODE_PUSH) && !closed_r && (cnt_ext < cap_eff);

    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    closed_nxt = closed_r;
    err_nxt    = err_r;

    if (take) begin
      case (cmd)
        bbsf_pkg::MODE_PUSH: begin
          if (push_ok) begin
            wp_nxt     = ptr_adv(wp_r, CNT_W'(1));
            cnt_nxt    = cnt_r + CNT_W'(1);
            pushed_nxt = pushed_r + TW'(1);
          end else begin
            err_nxt = 1'b1;
          end
        end
        bbsf_pkg::MODE_POP: begin
          rp_nxt     = ptr_adv(rp_r, n);
          cnt_nxt    = cnt_r - n;
          popped_nxt = popped_r + TW'(n);
        end
        bbsf_pkg::MODE_CLOSE: begin
          closed_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    cnt_nxt_ext = CMP_W'(cnt_nxt);
    room_nxt    = (cnt_nxt_ext >= cap_eff) ? '0 : cap_eff - cnt_nxt_ext;
    bypass_nxt  = push_ok && (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      wp_r     <= '0;
      cnt_r    <= '0;
      pushed_r <= '0;
      popped_r <= '0;
      closed_r <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      pushed_r <= pushed_nxt;
      popped_r <= popped_nxt;
      closed_r <= closed_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bypass_r <= bypass_nxt;
    byte_r   <= push_byte;
    room_r   <= room_nxt;
  end

  assign ram_we    = push_ok;
  assign ram_waddr = wp_r;
  assign ram_wdata = push_byte;
  assign ram_raddr = rp_nxt;

  always_comb begin
    status              = '0;
    status.front_valid  = (cnt_r != '0);
    status.front_byte   = (cnt_r == '0) ? '0 : (bypass_r ? byte_r : ram_rdata);
    status.occupancy    = cnt_ext[bbsf_pkg::CAP_W-1:0];
    status.free_room    = room_r[bbsf_pkg::CAP_W-1:0];
    status.total_pushed = pushed_r;
    status.total_popped = popped_r;
    status.closed       = closed_r;
    status.finished     = closed_r && (cnt_r == '0);
    status.error        = err_r;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == ptr_adv(rp_r, cnt_r))
    else $error("write pointer out of step with read pointer and count");

  a_refuse_err: assert property (@(posedge clk) disable iff (!rst_n)
    take && (cmd == bbsf_pkg::MODE_PUSH) && !push_ok |=> err_r)
    else $error("refused push did not set error");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed flag dropped");

endmodule
